### sv/scs_pkg.sv
// Shared types and constants for the game-record collection splitter.
package scs_pkg;

   // Byte codes seen by the framer
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   // Register file
   localparam int unsigned CSR_INDEX_BITS = 4;
   localparam int unsigned CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COMPACT_MODE = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_COUNT  = 4'd1;

   // Result queue geometry
   localparam int unsigned RQ_DEPTH    = 4;
   localparam int unsigned RQ_PTR_BITS = 2;
   localparam int unsigned RQ_CNT_BITS = 3;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [15:0] unit_number;
      logic        first_of_unit;
      logic        unit_complete;
      logic        last_of_run;
   } scs_result_type;

   // Results produced for one byte: count 0..2, in order r0 then r1
   typedef struct packed {
      logic [1:0]     n;
      scs_result_type r0;
      scs_result_type r1;
   } scs_emit_type;

   // One register write transfer
   typedef struct packed {
      logic                      wr;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  data;
   } scs_csr_type;

endpackage

### sv/sgf_collection_splitter_top.sv
// Collection splitter top: input register, framer and result queue.
// A byte is held in the input register, then its results are written into the result queue and offered from there.
// Throughput: one byte per cycle while the input does not stall; a byte with two results takes
// two queue entries, and the input stalls when the four-entry result queue lacks two free slots.
// Reset (synchronous): empties the pipeline, compact mode off, unit counter at 1.
module sgf_collection_splitter_top #(
   parameter int unsigned DEPTH_BITS = 16,
   parameter int unsigned UNIT_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_byte_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_out_byte,
   output logic [15:0]                         rsp_unit_number,
   output logic                                rsp_first_of_unit,
   output logic                                rsp_unit_complete,
   output logic                                rsp_last_of_run,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [scs_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [scs_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import scs_pkg::*;

   logic                   in_vld_ff, in_vld_in;
   logic [7:0]             in_byte_ff, in_byte_in;
   logic                   adv, room2;
   scs_csr_type            csr_wr;
   scs_emit_type           emit;
   scs_result_type         head;
   logic [RQ_CNT_BITS-1:0] q_level;

   // Input register: advances into the framer when the queue can take two results
   assign adv       = in_vld_ff && room2;
   assign req_stall = in_vld_ff && !room2;

   always_comb begin
      in_vld_in  = in_vld_ff && !adv;
      in_byte_in = in_byte_ff;
      if (req_valid && !req_stall) begin
         in_vld_in  = 1'b1;
         in_byte_in = req_byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   // Register write transfer
   assign csr_ready    = 1'b1;
   assign csr_wr.wr    = csr_valid && csr_ready;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_wdata;

   scs_framer #(
      .DEPTH_BITS(DEPTH_BITS),
      .UNIT_BITS (UNIT_BITS)
   ) u_framer (
      .clock  (clock),
      .reset  (reset),
      .csr_wr (csr_wr),
      .step   (adv),
      .byte_in(in_byte_ff),
      .emit   (emit)
   );

   scs_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (emit),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .head     (head),
      .room2    (room2),
      .level    (q_level)
   );

   assign rsp_out_byte      = head.out_byte;
   assign rsp_unit_number   = head.unit_number;
   assign rsp_first_of_unit = head.first_of_unit;
   assign rsp_unit_complete = head.unit_complete;
   assign rsp_last_of_run   = head.last_of_run;

`ifndef SYNTHESIS
   // queue never overfills
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      q_level <= RQ_CNT_BITS'(RQ_DEPTH))
      else $error("result queue overflow");

   // closing newline carries the unit end and closes the run
   a_complete_lf: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_unit_complete) |-> (rsp_out_byte == CH_LF && rsp_last_of_run))
      else $error("unit end on a result other than the closing newline");

   // no results are produced by a byte that never reached the framer
   a_push_needs_step: assert property (@(posedge clock) disable iff (reset)
      (emit.n != 2'd0) |-> adv)
      else $error("results pushed without an advancing byte");

   // nothing offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("results present after reset");
`endif

endmodule

### sv/scs_framer.sv
// Framing state machine: unit numbering, paren depth, value skipping, result build.
module scs_framer #(
   parameter int unsigned DEPTH_BITS = 16,
   parameter int unsigned UNIT_BITS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  scs_pkg::scs_csr_type csr_wr,
   input  logic                 step,
   input  logic [7:0]           byte_in,
   output scs_pkg::scs_emit_type emit
);
   import scs_pkg::*;

   localparam logic [2:0] PH_BETWEEN   = 3'd0;
   localparam logic [2:0] PH_WAIT_OPEN = 3'd1;
   localparam logic [2:0] PH_WAIT_SEMI = 3'd2;
   localparam logic [2:0] PH_GAME      = 3'd3;
   localparam logic [2:0] PH_VALUE     = 3'd4;
   localparam logic [2:0] PH_ESCAPE    = 3'd5;

   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
   localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);

   logic [2:0]            phase_ff, phase_in;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic                  in_game_ff, in_game_in;
   logic [UNIT_BITS-1:0]  counter_ff, counter_in;
   logic                  first_ff, first_in;
   logic                  compact_ff, compact_in;

   logic [2:0]            ph, nph;
   logic [DEPTH_BITS-1:0] dep, ndep, dec;
   logic                  ing, ning, fp;
   logic [UNIT_BITS-1:0]  cnt, unum;
   logic [UNIT_BITS+15:0] unum_ext, start_ext;
   logic                  between, ws, skip, emit_b;
   logic [1:0]            x_n, n;
   logic [7:0]            x0, x1, r0_byte, r1_byte;
   logic                  x_done, r0_done, r1_done;

   // Next state and result assembly for one byte
   always_comb begin
      between = !((phase_ff >= PH_WAIT_OPEN) && (phase_ff <= PH_ESCAPE));
      ws      = (byte_in == CH_SPACE) || (byte_in == CH_CR) || (byte_in == CH_LF);
      skip    = between && ws;

      ph  = phase_ff;
      dep = depth_ff;
      ing = in_game_ff;
      cnt = counter_ff;
      fp  = first_ff;
      // first non-blank byte between units opens a new unit
      if (between) begin
         cnt = counter_ff + 1'b1;
         fp  = 1'b1;
         ph  = PH_WAIT_OPEN;
         dep = '0;
         ing = 1'b0;
      end
      emit_b = ing || !compact_ff;

      nph    = ph;
      ndep   = dep;
      ning   = ing;
      x_n    = 2'd0;
      x0     = CH_LPAREN;
      x1     = CH_SEMI;
      x_done = 1'b0;
      dec    = dep;
      case (ph)
         PH_WAIT_OPEN: begin
            if (byte_in == CH_LPAREN) nph = PH_WAIT_SEMI;
         end
         PH_WAIT_SEMI: begin
            if (byte_in == CH_SEMI) begin
               nph  = PH_GAME;
               ndep = DEPTH_ONE;
               ning = 1'b1;
               // compact mode re-emits the opening pair
               if (compact_ff) x_n = 2'd2;
            end else begin
               nph = PH_WAIT_OPEN;
            end
         end
         PH_GAME: begin
            if (byte_in == CH_LPAREN) begin
               if (dep != DEPTH_MAX) ndep = dep + 1'b1;
            end else if (byte_in == CH_LBRACK) begin
               nph = PH_VALUE;
            end else if (byte_in == CH_RPAREN) begin
               if (dep != '0) dec = dep - 1'b1;
               ndep = dec;
               if (dec == '0) begin
                  ning   = 1'b0;
                  nph    = PH_BETWEEN;
                  x_n    = 2'd1;
                  x0     = CH_LF;
                  x_done = 1'b1;
               end
            end
         end
         PH_VALUE: begin
            if (byte_in == CH_RBRACK) nph = PH_GAME;
            else if (byte_in == CH_BSLASH) nph = PH_ESCAPE;
         end
         default: begin
            // escaped byte: back into the value
            nph = PH_VALUE;
         end
      endcase

      // order: passed byte first, then inserted bytes
      if (emit_b) begin
         n       = x_n + 2'd1;
         r0_byte = byte_in;
         r0_done = 1'b0;
         r1_byte = x0;
         r1_done = x_done;
      end else begin
         n       = x_n;
         r0_byte = x0;
         r0_done = x_done;
         r1_byte = x1;
         r1_done = 1'b0;
      end
      if (!step || skip) n = 2'd0;

      unum     = cnt - 1'b1;
      unum_ext = {16'b0, unum};

      emit.n                = n;
      emit.r0.out_byte      = r0_byte;
      emit.r0.unit_number   = unum_ext[15:0];
      emit.r0.first_of_unit = fp;
      emit.r0.unit_complete = r0_done;
      emit.r0.last_of_run   = (n == 2'd1);
      emit.r1.out_byte      = r1_byte;
      emit.r1.unit_number   = unum_ext[15:0];
      emit.r1.first_of_unit = 1'b0;
      emit.r1.unit_complete = r1_done;
      emit.r1.last_of_run   = 1'b1;

      phase_in   = phase_ff;
      depth_in   = depth_ff;
      in_game_in = in_game_ff;
      counter_in = counter_ff;
      first_in   = first_ff;
      compact_in = compact_ff;
      if (step && !skip) begin
         phase_in   = nph;
         depth_in   = ndep;
         in_game_in = ning;
         counter_in = cnt;
         first_in   = fp && (n == 2'd0);
      end

      // register writes; writing the start count loads the unit counter
      start_ext = {{UNIT_BITS{1'b0}}, csr_wr.data};
      if (csr_wr.wr) begin
         case (csr_wr.index)
            CSR_COMPACT_MODE: compact_in = csr_wr.data[0];
            CSR_START_COUNT:  counter_in = start_ext[UNIT_BITS-1:0];
            default:          compact_in = compact_ff;
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_BETWEEN;
         depth_ff   <= '0;
         in_game_ff <= 1'b0;
         counter_ff <= UNIT_BITS'(1);
         first_ff   <= 1'b0;
         compact_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         depth_ff   <= depth_in;
         in_game_ff <= in_game_in;
         counter_ff <= counter_in;
         first_ff   <= first_in;
         compact_ff <= compact_in;
      end
   end

endmodule

### sv/scs_rsp_queue.sv
// Small result queue: up to two pushes and one pop per cycle.
module scs_rsp_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  scs_pkg::scs_emit_type              push,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output scs_pkg::scs_result_type            head,
   output logic                               room2,
   output logic [scs_pkg::RQ_CNT_BITS-1:0]    level
);
   import scs_pkg::*;

   scs_result_type         mem_ff [RQ_DEPTH];
   logic [RQ_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RQ_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RQ_CNT_BITS-1:0] count_ff, count_in;
   logic                   pop;

   // Pointer and fill bookkeeping
   always_comb begin
      pop       = (count_ff != '0) && !rsp_stall;
      wr_ptr_in = wr_ptr_ff + RQ_PTR_BITS'(push.n);
      rd_ptr_in = rd_ptr_ff + RQ_PTR_BITS'(pop);
      count_in  = count_ff + RQ_CNT_BITS'(push.n) - RQ_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push.n != 2'd0) mem_ff[wr_ptr_ff] <= push.r0;
      if (push.n == 2'd2) mem_ff[wr_ptr_ff + 1'b1] <= push.r1;
   end

   assign rsp_valid = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];
   assign room2     = (count_ff <= RQ_CNT_BITS'(RQ_DEPTH - 2));
   assign level     = count_ff;

endmodule
